// ===== src/spq_pkg.sv =====
// shared types and codes for the stable priority queue
// no dependencies
package spq_pkg;

	localparam int PRI_W = 8;
	localparam int TAG_W = 16;
	localparam int OCC_W = 5;
	localparam int STATUS_W = 2;

	// input command codes
	localparam logic CMD_ENQUEUE = 1'b0;
	localparam logic CMD_DEQUEUE = 1'b1;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_PUSH,
		OP_POP
	} op_t;

	// controller to datapath
	typedef struct packed {
		op_t op;
		logic load;
		logic [STATUS_W-1:0] status;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic empty;
	} dp_stat_t;

endpackage

// ===== src/spq_in_if.sv =====
// request channel of the stable priority queue
// depends on spq_pkg
interface spq_in_if;
	logic valid;
	logic ready;
	logic command;
	logic [spq_pkg::PRI_W-1:0] entry_priority;
	logic [spq_pkg::TAG_W-1:0] entry_tag;

	modport source (output valid, command, entry_priority, entry_tag, input ready);
	modport sink (input valid, command, entry_priority, entry_tag, output ready);
endinterface

// ===== src/spq_out_if.sv =====
// result channel of the stable priority queue
// depends on spq_pkg
interface spq_out_if;
	logic valid;
	logic ready;
	logic [spq_pkg::STATUS_W-1:0] status;
	logic [spq_pkg::PRI_W-1:0] out_priority;
	logic [spq_pkg::TAG_W-1:0] out_tag;
	logic now_empty;
	logic [spq_pkg::OCC_W-1:0] occupancy;

	modport source (output valid, status, out_priority, out_tag, now_empty, occupancy,
		input ready);
	modport sink (input valid, status, out_priority, out_tag, now_empty, occupancy,
		output ready);
endinterface

// ===== src/spq_ctrl.sv =====
// controller: request/result handshake and command issue to the datapath
// depends on spq_pkg
module spq_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic in_command,
	output logic out_valid,
	input  logic out_ready,
	input  spq_pkg::dp_stat_t stat,
	output spq_pkg::dp_cmd_t cmd
);

	typedef enum logic {
		S_IDLE,
		S_HOLD
	} state_t;

	state_t state_q;
	logic accept;

	// take a new request when no result waits or the waiting one leaves now
	assign in_ready = (state_q == S_IDLE) || out_ready;
	assign accept = in_valid && in_ready;
	assign out_valid = (state_q == S_HOLD);

	always_comb begin
		cmd.op = spq_pkg::OP_NONE;
		cmd.load = accept;
		cmd.status = spq_pkg::ST_OK;
		if (accept) begin
			if (in_command == spq_pkg::CMD_ENQUEUE) begin
				if (stat.full) begin
					cmd.status = spq_pkg::ST_FULL;
				end else begin
					cmd.op = spq_pkg::OP_PUSH;
				end
			end else begin
				if (stat.empty) begin
					cmd.status = spq_pkg::ST_EMPTY;
				end else begin
					cmd.op = spq_pkg::OP_POP;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_HOLD;
				end
				S_HOLD: begin
					if (out_ready && !accept) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== src/spq_dp.sv =====
// datapath: sorted shift-register cells, fill count and result register
// depends on spq_pkg
module spq_dp #(
	parameter int CAPACITY = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  spq_pkg::dp_cmd_t cmd,
	input  logic [spq_pkg::PRI_W-1:0] new_pri,
	input  logic [spq_pkg::TAG_W-1:0] new_tag,
	output spq_pkg::dp_stat_t stat,
	output logic [spq_pkg::STATUS_W-1:0] res_status,
	output logic [spq_pkg::PRI_W-1:0] res_pri,
	output logic [spq_pkg::TAG_W-1:0] res_tag,
	output logic res_empty,
	output logic [spq_pkg::OCC_W-1:0] res_occ
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic [spq_pkg::PRI_W-1:0] pri_q [CAPACITY];
	logic [spq_pkg::TAG_W-1:0] tag_q [CAPACITY];
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	logic [CAPACITY-1:0] ins;

	logic [spq_pkg::STATUS_W-1:0] res_status_q;
	logic [spq_pkg::PRI_W-1:0] res_pri_q;
	logic [spq_pkg::TAG_W-1:0] res_tag_q;
	logic res_empty_q;
	logic [spq_pkg::OCC_W-1:0] res_occ_q;

	assign stat.full = (count_q == CNT_W'(CAPACITY));
	assign stat.empty = (count_q == '0);

	always_comb begin
		count_next = count_q;
		case (cmd.op)
			spq_pkg::OP_PUSH: count_next = count_q + CNT_W'(1);
			spq_pkg::OP_POP: count_next = count_q - CNT_W'(1);
			default: count_next = count_q;
		endcase
	end

	// a cell is at or behind the insertion point when it holds a larger key
	// or is the first free cell
	generate
		for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
			assign ins[i] = ((CNT_W'(i) < count_q) && (pri_q[i] > new_pri))
				|| (CNT_W'(i) == count_q);

			always_ff @(posedge clk) begin
				if (cmd.op == spq_pkg::OP_PUSH) begin
					if (i > 0 && ins[(i > 0) ? i - 1 : 0]) begin
						pri_q[i] <= pri_q[(i > 0) ? i - 1 : 0];
						tag_q[i] <= tag_q[(i > 0) ? i - 1 : 0];
					end else if (ins[i]) begin
						pri_q[i] <= new_pri;
						tag_q[i] <= new_tag;
					end
				end else if (cmd.op == spq_pkg::OP_POP && i < CAPACITY - 1) begin
					pri_q[i] <= pri_q[(i < CAPACITY - 1) ? i + 1 : i];
					tag_q[i] <= tag_q[(i < CAPACITY - 1) ? i + 1 : i];
				end
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_status_q <= cmd.status;
			res_pri_q <= (cmd.op == spq_pkg::OP_POP) ? pri_q[0] : '0;
			res_tag_q <= (cmd.op == spq_pkg::OP_POP) ? tag_q[0] : '0;
			res_empty_q <= (count_next == '0);
			res_occ_q <= spq_pkg::OCC_W'(count_next);
		end
	end

	assign res_status = res_status_q;
	assign res_pri = res_pri_q;
	assign res_tag = res_tag_q;
	assign res_empty = res_empty_q;
	assign res_occ = res_occ_q;

endmodule

// ===== src/stable_priority_queue_core.sv =====
// stable priority queue, top level: controller and datapath
// depends on spq_pkg, spq_in_if, spq_out_if, spq_ctrl, spq_dp
//
// A bounded queue of up to CAPACITY entries, each an 8-bit priority key and
// a 16-bit tag, kept sorted by ascending key in a row of shift-register
// cells. An enqueue slides every entry with a larger key one cell back and
// writes the new entry in front of them, so equal keys leave in arrival
// order; a dequeue returns the front cell and shifts the rest forward. Every
// request transfer yields exactly one result transfer with a status (ok,
// dropped because full, or dequeue from empty), the dequeued entry (zero
// otherwise), and the occupancy after the step. A request is executed in the
// cycle of its transfer, the result appears on the next cycle, and a new
// request is taken every cycle as long as the result side keeps up: the
// result register is the only stage, and the cell compare against the new
// key sets the cycle time. Entry storage has no reset; only the fill count
// and controller state are cleared, so the block is ready straight after reset.
module stable_priority_queue_core #(
	parameter int CAPACITY = 16
) (
	input logic clk,
	input logic arst_n,
	spq_in_if.sink req,
	spq_out_if.source rsp
);

	spq_pkg::dp_cmd_t cmd;
	spq_pkg::dp_stat_t stat;

	// handshake and status decision
	spq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (req.valid),
		.in_ready   (req.ready),
		.in_command (req.command),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	// sorted cells and result register
	spq_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.new_pri    (req.entry_priority),
		.new_tag    (req.entry_tag),
		.stat       (stat),
		.res_status (rsp.status),
		.res_pri    (rsp.out_priority),
		.res_tag    (rsp.out_tag),
		.res_empty  (rsp.now_empty),
		.res_occ    (rsp.occupancy)
	);

`ifndef SYNTHESIS
	// a waiting result that is not taken blocks new requests
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |-> !req.ready)
		else $error("request taken while result stalled");

	// an accepted request always produces a result next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> rsp.valid)
		else $error("accepted request gave no result");

	// non-ok results carry no entry
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != spq_pkg::ST_OK) |->
		(rsp.out_priority == '0 && rsp.out_tag == '0))
		else $error("entry returned with error status");

	// a dequeue from empty leaves the queue empty
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == spq_pkg::ST_EMPTY) |-> rsp.now_empty)
		else $error("empty status with entries held");

	// full status only when the queue holds its capacity
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status == spq_pkg::ST_FULL) |->
		(rsp.occupancy == spq_pkg::OCC_W'(CAPACITY) && !rsp.now_empty))
		else $error("full status below capacity");
`endif

endmodule
